// ----- hdl/lfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lfsc_pkg
// Shared types, constants, filter functions and the microcode table of the
// lfsr filter stream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsc_pkg;

   // nonlinear filter tables
   localparam logic [15:0] TBL4A = 16'h2C79;
   localparam logic [15:0] TBL4B = 16'h6671;
   localparam logic [31:0] TBL5  = 32'h7907287B;

   // widths
   localparam int unsigned STATE_W = 64;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned CNT_W   = 6;
   localparam int unsigned PC_W    = 4;
   localparam int unsigned CSR_W   = 2;

   // register indexes of the configuration port
   typedef enum logic [CSR_W-1:0] {
      CSR_KEY_LOW = 2'd0,
      CSR_KEY_MIX = 2'd1,
      CSR_SERIAL  = 2'd2
   } csr_index_type;

   // function codes of an input beat
   localparam logic FUNC_INIT  = 1'b0;
   localparam logic FUNC_CRYPT = 1'b1;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_LOAD,
      OP_INIT,
      OP_CRYPT,
      OP_EMIT
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_IS_INIT,
      C_CNT_ZERO,
      C_CNT_MORE,
      C_RSP_FREE
   } cond_type;

   // one control word
   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic is_init;
      logic cnt_zero;
      logic cnt_more;
      logic rsp_free;
   } status_type;

   // program steps
   localparam logic [PC_W-1:0] PC_FETCH = 4'd0;
   localparam logic [PC_W-1:0] PC_STEP  = 4'd3;
   localparam logic [PC_W-1:0] PC_EMIT  = 4'd4;
   localparam logic [PC_W-1:0] PC_LOAD  = 4'd6;
   localparam logic [PC_W-1:0] PC_ISTEP = 4'd7;

   // microcode table: jump to target when the condition holds, else next step
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         4'd0:    w = '{OP_ACCEPT, C_NO_REQ,   PC_FETCH};
         4'd1:    w = '{OP_NOP,    C_IS_INIT,  PC_LOAD};
         4'd2:    w = '{OP_NOP,    C_CNT_ZERO, PC_EMIT};
         4'd3:    w = '{OP_CRYPT,  C_CNT_MORE, PC_STEP};
         4'd4:    w = '{OP_EMIT,   C_RSP_FREE, PC_FETCH};
         4'd5:    w = '{OP_NOP,    C_ALWAYS,   PC_EMIT};
         4'd6:    w = '{OP_LOAD,   C_NEVER,    PC_FETCH};
         4'd7:    w = '{OP_INIT,   C_CNT_MORE, PC_ISTEP};
         4'd8:    w = '{OP_NOP,    C_ALWAYS,   PC_EMIT};
         default: w = '{OP_NOP,    C_ALWAYS,   PC_FETCH};
      endcase
      return w;
   endfunction

   // 20-input nonlinear filter
   function automatic logic filter20(input logic [STATE_W-1:0] s);
      logic [4:0] sel;
      sel[0] = TBL4A[{s[5],  s[4],  s[2],  s[1]}];
      sel[1] = TBL4B[{s[14], s[13], s[11], s[7]}];
      sel[2] = TBL4B[{s[25], s[22], s[20], s[16]}];
      sel[3] = TBL4B[{s[32], s[30], s[28], s[27]}];
      sel[4] = TBL4A[{s[45], s[43], s[42], s[33]}];
      return TBL5[sel];
   endfunction

   // 16-tap linear feedback
   function automatic logic feedback16(input logic [STATE_W-1:0] s);
      return s[0]  ^ s[2]  ^ s[3]  ^ s[6]  ^ s[7]  ^ s[8]  ^ s[16] ^ s[22] ^
             s[23] ^ s[26] ^ s[30] ^ s[41] ^ s[42] ^ s[43] ^ s[46] ^ s[47];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lfsr_filter_stream_cipher.sv -----
// crypt beat: bit_count cipher steps between acceptance and result (none for a
// zero count, bit_count saturating at 8); the result is registered at the emit step.
// init beat: 64 state steps; data_out is zero.
// the shared datapath does one cipher step per cycle.
// synchronous active-high reset clears keys, cipher state and the sequencer.
// ----------------------------------------------------------------------------
// lfsr_filter_stream_cipher
// Keystream cipher with a 64-bit state and 20-input filter, run by a
// microcoded sequencer over a one-step-per-cycle datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsr_filter_stream_cipher (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_func,
   input  wire  [63:0] req_iv,
   input  wire  [7:0]  req_data_in,
   input  wire  [3:0]  req_bit_count,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_data_out,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [63:0] csr_wdata
);

   lfsc_pkg::op_type     op;
   lfsc_pkg::status_type status;

   // sequencer
   lfsc_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .op        (op),
      .req_ready (req_ready)
   );

   // datapath
   lfsc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .req_valid     (req_valid),
      .req_func      (req_func),
      .req_iv        (req_iv),
      .req_data_in   (req_data_in),
      .req_bit_count (req_bit_count),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_data_out  (rsp_data_out)
   );

endmodule

`default_nettype wire

// ----- hdl/lfsc_useq.sv -----
// ----------------------------------------------------------------------------
// lfsc_useq
// Microcode sequencer: step counter, control word table and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_useq (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire lfsc_pkg::status_type status,
   output lfsc_pkg::op_type          op,
   output logic                      req_ready
);

   logic [lfsc_pkg::PC_W-1:0] pc_ff;
   logic [lfsc_pkg::PC_W-1:0] pc_in;
   lfsc_pkg::ucode_type       word;
   logic                      take;

   // control word of the current step
   assign word      = lfsc_pkg::ucode_rom(pc_ff);
   assign op        = word.op;
   assign req_ready = (word.op == lfsc_pkg::OP_ACCEPT);

   // jump condition
   always_comb begin
      case (word.cond)
         lfsc_pkg::C_NEVER:    take = 1'b0;
         lfsc_pkg::C_ALWAYS:   take = 1'b1;
         lfsc_pkg::C_NO_REQ:   take = !req_valid;
         lfsc_pkg::C_IS_INIT:  take = status.is_init;
         lfsc_pkg::C_CNT_ZERO: take = status.cnt_zero;
         lfsc_pkg::C_CNT_MORE: take = status.cnt_more;
         lfsc_pkg::C_RSP_FREE: take = status.rsp_free;
         default:              take = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (take) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= lfsc_pkg::PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lfsc_datapath.sv -----
// ----------------------------------------------------------------------------
// lfsc_datapath
// Cipher state, key registers, step counter, data byte and result register,
// driven one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  wire lfsc_pkg::op_type op,
   input  wire                   req_valid,
   input  wire                   req_func,
   input  wire  [63:0]           req_iv,
   input  wire  [7:0]            req_data_in,
   input  wire  [3:0]            req_bit_count,
   input  wire                   csr_we,
   input  wire  [1:0]            csr_index,
   input  wire  [63:0]           csr_wdata,
   input  wire                   rsp_ready,
   output lfsc_pkg::status_type  status,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_data_out
);

   logic [31:0] key_low_ff;
   logic [63:0] key_mix_ff;
   logic [31:0] serial_ff;
   logic [63:0] state_ff, state_in;
   logic [63:0] iv_ff;
   logic [7:0]  data_ff, data_in;
   logic        func_ff;
   logic        zero_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic [5:0]  last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff;

   logic [63:0] shifted;
   logic [16:0] upper;
   logic [63:0] crypt_next;
   logic [63:0] init_next;
   logic        init_bit;
   logic        rsp_free;
   logic [3:0]  sat_count;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= '0;
         key_mix_ff <= '0;
         serial_ff  <= '0;
      end else if (csr_we) begin
         case (lfsc_pkg::csr_index_type'(csr_index))
            lfsc_pkg::CSR_KEY_LOW: key_low_ff <= csr_wdata[31:0];
            lfsc_pkg::CSR_KEY_MIX: key_mix_ff <= csr_wdata;
            lfsc_pkg::CSR_SERIAL:  serial_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // one cipher step in each mode
   always_comb begin
      shifted    = {1'b0, state_ff[63:1]};
      upper      = shifted[63:47] + {16'd0, lfsc_pkg::feedback16(state_ff)};
      crypt_next = {upper, shifted[46:0]};
      init_bit   = lfsc_pkg::filter20(shifted) ^ iv_ff[cnt_ff] ^ key_mix_ff[cnt_ff];
      init_next  = {init_bit, shifted[62:0]};
   end

   assign sat_count = (req_bit_count > 4'd8) ? 4'd8 : req_bit_count;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // operation decode
   always_comb begin
      state_in     = state_ff;
      data_in      = data_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (op)
         lfsc_pkg::OP_ACCEPT: begin
            cnt_in  = '0;
            last_in = {2'd0, sat_count} - 6'd1;
            data_in = req_data_in;
         end
         lfsc_pkg::OP_LOAD: begin
            state_in = {key_low_ff, serial_ff};
            data_in  = '0;
            cnt_in   = '0;
            last_in  = 6'd63;
         end
         lfsc_pkg::OP_INIT: begin
            state_in = init_next;
            cnt_in   = cnt_ff + 6'd1;
         end
         lfsc_pkg::OP_CRYPT: begin
            state_in = crypt_next;
            data_in  = data_ff ^ ({7'd0, lfsc_pkg::filter20(crypt_next)} << 7
                                  >> cnt_ff[2:0]);
            cnt_in   = cnt_ff + 6'd1;
         end
         lfsc_pkg::OP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // cipher state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
      if (op == lfsc_pkg::OP_ACCEPT && req_valid) begin
         func_ff <= req_func;
         iv_ff   <= req_iv;
         zero_ff <= (sat_count == 4'd0);
      end
      if (op == lfsc_pkg::OP_EMIT && rsp_free) begin
         rsp_data_ff <= data_ff;
      end
   end

   // status to the sequencer
   assign status.is_init  = (func_ff == lfsc_pkg::FUNC_INIT);
   assign status.cnt_zero = zero_ff;
   assign status.cnt_more = (cnt_ff != last_ff);
   assign status.rsp_free = rsp_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

endmodule

`default_nettype wire
